>>> sv/tlcs_pkg.sv
// Shared types and constants for the text line and character segmenter.
package tlcs_pkg;

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int ROW_OUT_W   = 10;
  localparam int COL_OUT_W   = 7;
  localparam int END_OUT_W   = 8;
  localparam int INDEX_OUT_W = 6;
  localparam int HDR_WIDTH_W = 8;

  // Band header handed from the front end to the scanner with the column bitmap.
  typedef struct packed {
    logic [ROW_OUT_W-1:0]   top;
    logic [ROW_OUT_W-1:0]   bottom;
    logic [HDR_WIDTH_W-1:0] width;
  } band_hdr_t;

  // One character box as delivered on the result channel.
  typedef struct packed {
    logic [ROW_OUT_W-1:0]   top;
    logic [ROW_OUT_W-1:0]   bottom;
    logic [COL_OUT_W-1:0]   first_col;
    logic [END_OUT_W-1:0]   end_col;
    logic [INDEX_OUT_W-1:0] index;
    logic                   last;
  } box_t;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_RUN,
    SCAN_FLUSH
  } scan_state_t;

endpackage

>>> sv/tlcs_front.sv
// Pixel front end: row and band tracking, column occupancy, band hand-off.
module tlcs_front
  import tlcs_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [10:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  input  logic                          q_full,
  output logic                          q_push,
  output band_hdr_t                     q_hdr,
  output logic [MAX_WIDTH-1:0]          q_bits
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RXW = (RW > ROW_OUT_W) ? RW : ROW_OUT_W;
  localparam int HEIGHT_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  logic [WW-1:0]        width_r, width_nxt;
  logic [HW-1:0]        height_r, height_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic                 dark_r, dark_nxt;
  logic                 inband_r, inband_nxt;
  logic [RW-1:0]        start_r, start_nxt;
  logic [MAX_WIDTH-1:0] redz_r, redz_nxt;
  logic [MAX_WIDTH-1:0] occ_r, occ_nxt;

  logic                 fire;
  logic                 dark_cur;
  logic [MAX_WIDTH-1:0] redz_cur;
  logic                 row_end;
  logic                 frame_end;
  logic [RXW-1:0]       start_x;
  logic [RXW-1:0]       bottom_x;
  logic [7:0]           cfg_w8;
  logic [10:0]          cfg_h11;

  assign in_ready  = !q_full;
  assign fire      = in_valid && in_ready;
  assign dark_cur  = dark_r || ((in_red == 8'd0) && (in_green == 8'd0) && (in_blue == 8'd0));
  assign redz_cur  = redz_r | ((in_red == 8'd0) ? (MAX_WIDTH'(1) << col_r) : '0);
  assign row_end   = !((WW'(col_r) + WW'(1)) < width_r);
  assign frame_end = !((HW'(row_r) + HW'(1)) < height_r);

  // A band closes on the last pixel of the first row without a dark pixel.
  assign q_push    = fire && row_end && !dark_cur && inband_r;
  assign start_x   = RXW'(start_r);
  assign bottom_x  = RXW'(row_r) - RXW'(1);
  assign q_hdr.top    = start_x[ROW_OUT_W-1:0];
  assign q_hdr.bottom = bottom_x[ROW_OUT_W-1:0];
  assign q_hdr.width  = HDR_WIDTH_W'(width_r);
  assign q_bits       = occ_r;

  assign cfg_w8  = cfg_data[7:0];
  assign cfg_h11 = cfg_data[10:0];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_w8 == 8'd0) begin
            width_nxt = WW'(1);
          end else if (int'(cfg_w8) > MAX_WIDTH) begin
            width_nxt = WW'(MAX_WIDTH);
          end else begin
            width_nxt = WW'(cfg_w8);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_h11 == 11'd0) begin
            height_nxt = HW'(1);
          end else if (int'(cfg_h11) > MAX_HEIGHT) begin
            height_nxt = HW'(MAX_HEIGHT);
          end else begin
            height_nxt = HW'(cfg_h11);
          end
        end
        default: begin
          width_nxt = width_r;
        end
      endcase
    end
  end

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    dark_nxt   = dark_r;
    inband_nxt = inband_r;
    start_nxt  = start_r;
    redz_nxt   = redz_r;
    occ_nxt    = occ_r;
    if (fire) begin
      if (!row_end) begin
        col_nxt  = col_r + CW'(1);
        redz_nxt = redz_cur;
        dark_nxt = dark_cur;
      end else begin
        col_nxt  = '0;
        redz_nxt = '0;
        dark_nxt = 1'b0;
        if (dark_cur) begin
          if (!inband_r) begin
            inband_nxt = 1'b1;
            start_nxt  = row_r;
            occ_nxt    = redz_cur;
          end else begin
            occ_nxt = occ_r | redz_cur;
          end
        end else if (inband_r) begin
          inband_nxt = 1'b0;
        end
        if (!frame_end) begin
          row_nxt = row_r + RW'(1);
        end else begin
          // A band still open at frame end is dropped.
          row_nxt    = '0;
          inband_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(MAX_WIDTH);
      height_r <= HW'(HEIGHT_RST);
      col_r    <= '0;
      row_r    <= '0;
      dark_r   <= 1'b0;
      inband_r <= 1'b0;
      start_r  <= '0;
      redz_r   <= '0;
      occ_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      dark_r   <= dark_nxt;
      inband_r <= inband_nxt;
      start_r  <= start_nxt;
      redz_r   <= redz_nxt;
      occ_r    <= occ_nxt;
    end
  end

endmodule

>>> sv/tlcs_fifo.sv
// Two-entry queue of closed bands between the front end and the scanner.
module tlcs_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          full,
  output logic          empty
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/tlcs_back.sv
// Band scanner: walks the column bitmap one column a cycle, stalling on a held output, and emits boxes.
module tlcs_back
  import tlcs_pkg::*;
#(
  parameter int MAX_WIDTH = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  band_hdr_t            q_hdr,
  input  logic [MAX_WIDTH-1:0] q_bits,
  output logic                 out_valid,
  input  logic                 out_ready,
  output box_t                 out_box
);

  scan_state_t          state_r, state_nxt;
  logic [MAX_WIDTH-1:0] bits_r, bits_nxt;
  logic [7:0]           x_r, x_nxt;
  logic [7:0]           width_r, width_nxt;
  logic [9:0]           top_r, top_nxt;
  logic [9:0]           bot_r, bot_nxt;
  logic                 open_r, open_nxt;
  logic [6:0]           start_r, start_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [6:0]           pend_first_r, pend_first_nxt;
  logic [7:0]           pend_end_r, pend_end_nxt;
  logic [5:0]           pend_idx_r, pend_idx_nxt;
  logic                 out_v_r, out_v_nxt;
  box_t                 out_box_r, out_box_nxt;

  logic out_free;
  logic closing;
  logic step;
  logic last_col;

  assign out_free = !out_v_r || out_ready;
  // A blank column after a marked one closes a run.
  assign closing  = (state_r == SCAN_RUN) && !bits_r[0] && open_r;
  // A closing run displaces the pending box, which needs the output register.
  assign step     = (state_r == SCAN_RUN) && !(closing && pend_v_r && !out_free);
  assign last_col = (x_r + 8'd1) == width_r;
  assign q_pop    = (state_r == SCAN_IDLE) && !q_empty;

  assign out_valid = out_v_r;
  assign out_box   = out_box_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SCAN_IDLE: begin
        if (!q_empty) begin
          state_nxt = SCAN_RUN;
        end
      end
      SCAN_RUN: begin
        if (step && last_col) begin
          state_nxt = SCAN_FLUSH;
        end
      end
      SCAN_FLUSH: begin
        if (!pend_v_r || out_free) begin
          state_nxt = SCAN_IDLE;
        end
      end
      default: begin
        state_nxt = SCAN_IDLE;
      end
    endcase
  end

  always_comb begin
    bits_nxt       = bits_r;
    x_nxt          = x_r;
    width_nxt      = width_r;
    top_nxt        = top_r;
    bot_nxt        = bot_r;
    open_nxt       = open_r;
    start_nxt      = start_r;
    cnt_nxt        = cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_first_nxt = pend_first_r;
    pend_end_nxt   = pend_end_r;
    pend_idx_nxt   = pend_idx_r;
    out_v_nxt      = out_ready ? 1'b0 : out_v_r;
    out_box_nxt    = out_box_r;
    unique case (state_r)
      SCAN_IDLE: begin
        if (!q_empty) begin
          bits_nxt   = q_bits;
          width_nxt  = q_hdr.width;
          top_nxt    = q_hdr.top;
          bot_nxt    = q_hdr.bottom;
          x_nxt      = 8'd0;
          open_nxt   = 1'b0;
          cnt_nxt    = 6'd0;
          pend_v_nxt = 1'b0;
        end
      end
      SCAN_RUN: begin
        if (step) begin
          bits_nxt = bits_r >> 1;
          x_nxt    = x_r + 8'd1;
          if (bits_r[0]) begin
            if (!open_r) begin
              open_nxt  = 1'b1;
              start_nxt = x_r[6:0];
            end
          end else if (open_r) begin
            if (pend_v_r) begin
              out_v_nxt             = 1'b1;
              out_box_nxt.top       = top_r;
              out_box_nxt.bottom    = bot_r;
              out_box_nxt.first_col = pend_first_r;
              out_box_nxt.end_col   = pend_end_r;
              out_box_nxt.index     = pend_idx_r;
              out_box_nxt.last      = 1'b0;
            end
            pend_v_nxt     = 1'b1;
            pend_first_nxt = start_r;
            pend_end_nxt   = x_r + 8'd1;
            pend_idx_nxt   = cnt_r;
            cnt_nxt        = cnt_r + 6'd1;
            open_nxt       = 1'b0;
          end
        end
      end
      SCAN_FLUSH: begin
        if (pend_v_r && out_free) begin
          out_v_nxt             = 1'b1;
          out_box_nxt.top       = top_r;
          out_box_nxt.bottom    = bot_r;
          out_box_nxt.first_col = pend_first_r;
          out_box_nxt.end_col   = pend_end_r;
          out_box_nxt.index     = pend_idx_r;
          out_box_nxt.last      = 1'b1;
          pend_v_nxt            = 1'b0;
        end
      end
      default: begin
        pend_v_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bits_r       <= bits_nxt;
    x_r          <= x_nxt;
    width_r      <= width_nxt;
    top_r        <= top_nxt;
    bot_r        <= bot_nxt;
    open_r       <= open_nxt;
    start_r      <= start_nxt;
    cnt_r        <= cnt_nxt;
    pend_first_r <= pend_first_nxt;
    pend_end_r   <= pend_end_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_box_r    <= out_box_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SCAN_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

endmodule

>>> sv/text_line_char_segmenter_core.sv
// Top level of the text line and character segmenter.
//
// Pixels enter on the in_ stream in raster order, one transaction per pixel,
// red/green/blue packed in in_tdata. Rows of image_width pixels and frames of
// image_height rows are set through the cfg_ write channel (index 0 is the
// width, index 1 the height); write them only while the block is idle.
// Each character box leaves on the out_ stream as one transaction; out_tlast
// marks the last box of a band.
// Throughput: one pixel per cycle. in_tready drops only while two closed bands
// are queued ahead of the column scanner.
// The scanner picks a band up from the queue once it is idle, walks its columns
// in order and then flushes the pending box. A box is presented when the next
// run of its band closes; the last box of a band is presented from the flush
// step, once the output register is free.
// When the receiver stalls, the scanner halts as soon as a box has to move into
// the held output register, and the queue absorbs up to two further bands
// before the pixel input stalls.
// Reset (rst_n low, synchronous) clears row and column positions, band state,
// queue and output, and restores the full width and a height of MAX_HEIGHT, capped at 1024.
module text_line_char_segmenter_core
  import tlcs_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  // band_top_row[9:0], band_bottom_row[19:10], first_column[26:20],
  // end_column[34:27], char_index[40:35], zero[47:41]
  output logic [47:0] out_tdata,
  output logic        out_tlast   // last_of_band
);

  localparam int QW = $bits(band_hdr_t) + MAX_WIDTH;

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  band_hdr_t            push_hdr;
  logic [MAX_WIDTH-1:0] push_bits;
  logic [QW-1:0]        pop_data;
  band_hdr_t            pop_hdr;
  logic [MAX_WIDTH-1:0] pop_bits;
  box_t                 box;

  assign cfg_ready = 1'b1;

  tlcs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_red    (in_tdata[7:0]),
    .in_green  (in_tdata[15:8]),
    .in_blue   (in_tdata[23:16]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_hdr     (push_hdr),
    .q_bits    (push_bits)
  );

  tlcs_fifo #(
    .DW (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_hdr, push_bits}),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign pop_hdr  = pop_data[QW-1:MAX_WIDTH];
  assign pop_bits = pop_data[MAX_WIDTH-1:0];

  tlcs_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_hdr     (pop_hdr),
    .q_bits    (pop_bits),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_box   (box)
  );

  assign out_tdata = {7'd0, box.index, box.end_col, box.first_col, box.bottom, box.top};
  assign out_tlast = box.last;

endmodule
